### rtl/tonemap_pkg.sv
package tonemap_pkg;

   localparam int FRAC_BITS_DEFAULT = 12;
   localparam int SUM_W = 24;
   localparam int COUNT_W = 11;
   localparam int GAMMA_W = 16;
   localparam int CODE_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 11'd1;
   localparam logic [GAMMA_W-1:0] INVERSE_GAMMA_RESET = 16'd1862;

   // Quotient bits, log2 fraction bits, exponent fraction bits.
   localparam int Q_BITS = 32;
   localparam int LOG_BITS = 24;
   localparam int EXP_BITS = 16;
   localparam int EXPO_W = 6;

   localparam int CURVE_LAT = 2;
   localparam int DIV_LAT = Q_BITS;
   localparam int LOG_LAT = LOG_BITS + 1;
   localparam int EXP_LAT = EXP_BITS + 2;
   localparam int PIPE_LAT = CURVE_LAT + DIV_LAT + LOG_LAT + EXP_LAT;

   typedef enum logic [0:0] {
      CSR_SAMPLE_COUNT  = 1'b0,
      CSR_INVERSE_GAMMA = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic sat;
      logic zero;
   } flags_type;

   // Width that holds both curve polynomials for a given fraction width.
   function automatic int value_width(input int frac_bits);
      int dw;
      int a;
      int b;
      int c;
      int w;
      dw = COUNT_W + frac_bits;
      a = 2 * SUM_W + 8;
      b = SUM_W + dw + 6;
      c = 2 * dw + 4;
      w = a;
      if (b > w) w = b;
      if (c > w) w = c;
      return w + 2;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x = x_in;
      res = 64'd0;
      bitv = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bitv > x) bitv = bitv >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bitv != 64'd0) begin
            if (x >= res + bitv) begin
               x = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // 2^(-2^-i) in Q0.32, built by repeated truncated square roots of one half.
   function automatic logic [31:0] root_value(input int idx);
      logic [63:0] r;
      r = 64'h0000_0000_8000_0000;
      for (int k = 1; k <= EXP_BITS; k++) begin
         if (k <= idx) r = isqrt64(r << 32);
      end
      return r[31:0];
   endfunction

endpackage

### rtl/tonemap_curve.sv
module tonemap_curve
   import tonemap_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int VW = value_width(FRAC_BITS)
) (
   input  logic               clock,
   input  logic               en,
   input  logic [SUM_W-1:0]   sum,
   input  logic [COUNT_W-1:0] count,
   output logic [VW-1:0]      num,
   output logic [VW-1:0]      den
);

   localparam int DW = COUNT_W + FRAC_BITS;

   logic [COUNT_W-1:0] n;
   logic [DW-1:0] d;
   logic [2*SUM_W-1:0] ss_ff;
   logic [SUM_W+DW-1:0] sd_ff;
   logic [2*DW-1:0] dd_ff;
   logic [VW-1:0] num_ff;
   logic [VW-1:0] den_ff;
   logic [VW-1:0] num_in;
   logic [VW-1:0] den_in;

   // A zero sample count averages as one.
   always_comb begin
      n = (count == '0) ? COUNT_W'(1) : count;
      d = DW'(n) << FRAC_BITS;
   end

   always_comb begin
      num_in = VW'(251) * VW'(ss_ff) + VW'(3) * VW'(sd_ff);
      den_in = VW'(243) * VW'(ss_ff) + VW'(59) * VW'(sd_ff) + VW'(14) * VW'(dd_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff <= (2*SUM_W)'(sum) * (2*SUM_W)'(sum);
         sd_ff <= (SUM_W+DW)'(sum) * (SUM_W+DW)'(d);
         dd_ff <= (2*DW)'(d) * (2*DW)'(d);
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign num = num_ff;
   assign den = den_ff;

endmodule

### rtl/tonemap_div.sv
module tonemap_div
   import tonemap_pkg::*;
#(
   parameter int VW = value_width(FRAC_BITS_DEFAULT)
) (
   input  logic              clock,
   input  logic              en,
   input  logic [VW-1:0]     num,
   input  logic [VW-1:0]     den,
   output logic [Q_BITS-1:0] y,
   output flags_type         flags
);

   logic [VW-1:0] rem_ff [Q_BITS];
   logic [VW-1:0] den_ff [Q_BITS];
   logic [Q_BITS-1:0] q_ff [Q_BITS];
   logic sat_ff [Q_BITS];

   // One restoring step per stage, most significant quotient bit first.
   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      logic [VW-1:0] rem_prev;
      logic [VW-1:0] den_prev;
      logic [Q_BITS-1:0] q_prev;
      logic sat_prev;
      logic [VW:0] trial;
      logic [VW:0] diff;
      logic fits;
      logic [VW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign q_prev = '0;
         assign sat_prev = (num >= den);
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign sat_prev = sat_ff[k-1];
      end

      always_comb begin
         trial = {rem_prev, 1'b0};
         fits = (trial >= {1'b0, den_prev});
         diff = trial - {1'b0, den_prev};
         rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            q_ff[k] <= {q_prev[Q_BITS-2:0], fits};
            sat_ff[k] <= sat_prev;
         end
      end
   end

   assign y = q_ff[Q_BITS-1];
   assign flags.sat = sat_ff[Q_BITS-1];
   assign flags.zero = 1'b0;

endmodule

### rtl/tonemap_log2.sv
module tonemap_log2
   import tonemap_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [Q_BITS-1:0]   y,
   input  flags_type           flags_in,
   output logic [LOG_BITS-1:0] frac,
   output logic [EXPO_W-1:0]   expo,
   output flags_type           flags_out
);

   logic [31:0] m_ff [LOG_BITS+1];
   logic [LOG_BITS-1:0] frac_ff [LOG_BITS+1];
   logic [EXPO_W-1:0] expo_ff [LOG_BITS+1];
   flags_type flags_ff [LOG_BITS+1];

   logic [4:0] msb;
   logic [31:0] m_in;
   logic [EXPO_W-1:0] expo_in;
   flags_type flags_in_next;

   // Leading one position; the mantissa is normalized to [1, 2) in Q1.31.
   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < Q_BITS; i++) begin
         if (y[i]) msb = 5'(i);
      end
      m_in = y << (5'd31 - msb);
      expo_in = 6'd32 - {1'b0, msb};
      flags_in_next.sat = flags_in.sat;
      flags_in_next.zero = (y == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= m_in;
         frac_ff[0] <= '0;
         expo_ff[0] <= expo_in;
         flags_ff[0] <= flags_in_next;
      end
   end

   // Each squaring yields one fraction bit of the logarithm.
   for (genvar k = 1; k <= LOG_BITS; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] sh;
      logic [31:0] m_next;

      always_comb begin
         sq = 64'(m_ff[k-1]) * 64'(m_ff[k-1]);
         sh = sq[63:31];
         m_next = sh[32] ? sh[32:1] : sh[31:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k] <= m_next;
            frac_ff[k] <= {frac_ff[k-1][LOG_BITS-2:0], sh[32]};
            expo_ff[k] <= expo_ff[k-1];
            flags_ff[k] <= flags_ff[k-1];
         end
      end
   end

   assign frac = frac_ff[LOG_BITS];
   assign expo = expo_ff[LOG_BITS];
   assign flags_out = flags_ff[LOG_BITS];

endmodule

### rtl/tonemap_exp2.sv
module tonemap_exp2
   import tonemap_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [LOG_BITS-1:0] frac,
   input  logic [EXPO_W-1:0]   expo,
   input  flags_type           flags,
   input  logic [GAMMA_W-1:0]  gamma,
   output logic [CODE_W-1:0]   code
);

   localparam int NEG_W = EXPO_W + LOG_BITS;
   localparam int T_W = NEG_W + GAMMA_W;
   localparam int TI_W = T_W - 36;

   logic [32:0] acc_ff [EXP_BITS+1];
   logic [EXP_BITS-1:0] tf_ff [EXP_BITS+1];
   logic [TI_W-1:0] ti_ff [EXP_BITS+1];
   flags_type flags_ff [EXP_BITS+1];
   logic [CODE_W-1:0] code_ff;

   logic [NEG_W-1:0] neg;
   logic [T_W-1:0] t;
   logic [32:0] shifted;
   logic [CODE_W-1:0] code_in;

   // t = -log2(y) * inverse_gamma, integer part and top fraction bits kept.
   always_comb begin
      neg = {expo, {LOG_BITS{1'b0}}} - NEG_W'(frac);
      t = T_W'(neg) * T_W'(gamma);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0] <= 33'h1_0000_0000;
         tf_ff[0] <= t[35:20];
         ti_ff[0] <= t[T_W-1:36];
         flags_ff[0] <= flags;
      end
   end

   for (genvar k = 1; k <= EXP_BITS; k++) begin : g_root
      localparam logic [31:0] ROOT = root_value(k);
      logic [64:0] prod;
      logic [32:0] acc_next;

      always_comb begin
         prod = 65'(acc_ff[k-1]) * 65'(ROOT);
         acc_next = tf_ff[k-1][EXP_BITS-k] ? prod[64:32] : acc_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_next;
            tf_ff[k] <= tf_ff[k-1];
            ti_ff[k] <= ti_ff[k-1];
            flags_ff[k] <= flags_ff[k-1];
         end
      end
   end

   always_comb begin
      shifted = acc_ff[EXP_BITS] >> ti_ff[EXP_BITS];
      if (flags_ff[EXP_BITS].sat) begin
         code_in = '1;
      end else if (flags_ff[EXP_BITS].zero || ti_ff[EXP_BITS] >= TI_W'(33)) begin
         code_in = '0;
      end else if (shifted[32]) begin
         code_in = '1;
      end else begin
         code_in = shifted[31:24];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

### rtl/hdr_pixel_tonemap_gamma_quantize.sv
// An accepted request passes through the curve, divider, log2 and exp2 stages to its response.
// Throughput: one pixel per cycle; the pipeline holds as a whole while the
// output register waits on rsp_stall, so a stalled response stalls requests.
// The divider (32 stages), log2 squarer (25) and exp2 multiplier chain (18) set the depth.
// Reset (synchronous) empties the pipeline and loads sample_count 1, inverse_gamma 1862.
module hdr_pixel_tonemap_gamma_quantize
   import tonemap_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SUM_W-1:0]      req_red_sum,
   input  logic [SUM_W-1:0]      req_green_sum,
   input  logic [SUM_W-1:0]      req_blue_sum,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_red_out,
   output logic [CODE_W-1:0]     rsp_green_out,
   output logic [CODE_W-1:0]     rsp_blue_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int VW = value_width(FRAC_BITS);

   logic [COUNT_W-1:0] sample_count_ff;
   logic [GAMMA_W-1:0] inverse_gamma_ff;
   logic [PIPE_LAT-1:0] valid_ff;
   logic pipe_en;

   logic [SUM_W-1:0] sum_ch [3];
   logic [CODE_W-1:0] code_ch [3];

   assign csr_ready = 1'b1;
   assign pipe_en = !(valid_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !pipe_en;
   assign rsp_valid = valid_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
         inverse_gamma_ff <= INVERSE_GAMMA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_data[COUNT_W-1:0];
            CSR_INVERSE_GAMMA: inverse_gamma_ff <= csr_data[GAMMA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   assign sum_ch[0] = req_red_sum;
   assign sum_ch[1] = req_green_sum;
   assign sum_ch[2] = req_blue_sum;

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [VW-1:0] num;
      logic [VW-1:0] den;
      logic [Q_BITS-1:0] y;
      flags_type div_flags;
      logic [LOG_BITS-1:0] frac;
      logic [EXPO_W-1:0] expo;
      flags_type log_flags;

      tonemap_curve #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_curve (
         .clock(clock), .en(pipe_en), .sum(sum_ch[c]), .count(sample_count_ff),
         .num(num), .den(den)
      );

      tonemap_div #(.VW(VW)) u_div (
         .clock(clock), .en(pipe_en), .num(num), .den(den),
         .y(y), .flags(div_flags)
      );

      tonemap_log2 u_log2 (
         .clock(clock), .en(pipe_en), .y(y), .flags_in(div_flags),
         .frac(frac), .expo(expo), .flags_out(log_flags)
      );

      tonemap_exp2 u_exp2 (
         .clock(clock), .en(pipe_en), .frac(frac), .expo(expo), .flags(log_flags),
         .gamma(inverse_gamma_ff), .code(code_ch[c])
      );
   end

   assign rsp_red_out = code_ch[0];
   assign rsp_green_out = code_ch[1];
   assign rsp_blue_out = code_ch[2];

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_ff))
      else $error("pipeline valid bits moved while stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
